FILE: hdl/udec_pkg.sv
// ----------------------------------------------------------------------------
// udec_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package udec_pkg;

    localparam logic [15:0] REPL_RESET   = 16'h005F;
    localparam logic [7:0]  LEAD2_FIRST  = 8'hC0;
    localparam logic [7:0]  LEAD3_FIRST  = 8'hE0;
    localparam logic [7:0]  LEAD4_FIRST  = 8'hF0;
    localparam logic [7:0]  LEAD5_FIRST  = 8'hF8;
    localparam logic [7:0]  LEAD6_FIRST  = 8'hFC;
    localparam logic [7:0]  BAD_FIRST    = 8'hFE;
    localparam logic [2:0]  SKIP_LEAD4   = 3'd3;
    localparam logic [2:0]  SKIP_LEAD5   = 3'd4;
    localparam logic [2:0]  SKIP_LEAD6   = 3'd5;
    localparam int          QUEUE_DEPTH  = 4;

    typedef struct packed {
        logic [15:0] code_point;
        logic        is_repl;
        logic        str_valid;
        logic        last;
    } udec_result_t;

    // results produced by one byte, in order; count is 0, 1 or 2
    typedef struct packed {
        logic [1:0]   count;
        udec_result_t slot0;
        udec_result_t slot1;
    } udec_push_t;

endpackage

FILE: hdl/udec_decode.sv
// ----------------------------------------------------------------------------
// udec_decode
// Sequence state and single-pass decode of one byte into up to two results.
// ----------------------------------------------------------------------------
module udec_decode (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  go,
    input  logic [7:0]            data_byte,
    input  logic                  eos,
    input  logic [15:0]           repl_char,
    output udec_pkg::udec_push_t  push
);

    logic [7:0] lead_reg,   lead_next;
    logic [7:0] second_reg, second_next;
    logic [2:0] seen_reg,   seen_next;
    logic [2:0] skip_reg,   skip_next;
    logic       err_reg,    err_next;

    always_comb begin
        logic                   is_cont;
        logic                   a_v, a_rep, s_v, s_rep, f_v, do_start;
        logic [15:0]            a_cp, s_cp;
        udec_pkg::udec_result_t ca, cs, cf;
        udec_pkg::udec_push_t   p;

        is_cont     = (data_byte[7:6] == 2'b10);
        a_v         = 1'b0;
        a_rep       = 1'b0;
        a_cp        = 16'd0;
        s_v         = 1'b0;
        s_rep       = 1'b0;
        s_cp        = 16'd0;
        f_v         = 1'b0;
        do_start    = 1'b0;
        lead_next   = lead_reg;
        second_next = second_reg;
        seen_next   = seen_reg;
        skip_next   = skip_reg;

        if (seen_reg == 3'd0) begin
            do_start = 1'b1;
        end else if (!is_cont) begin
            // early break: reject pending sequence, then redo byte as a lead
            a_v       = 1'b1;
            a_rep     = 1'b1;
            seen_next = 3'd0;
            do_start  = 1'b1;
        end else if (lead_reg >= udec_pkg::LEAD4_FIRST) begin
            if (seen_reg >= skip_reg) begin
                a_v       = 1'b1;
                a_rep     = 1'b1;
                seen_next = 3'd0;
            end else begin
                seen_next = seen_reg + 3'd1;
            end
        end else if (lead_reg >= udec_pkg::LEAD3_FIRST) begin
            if (seen_reg == 3'd1) begin
                second_next = data_byte;
                seen_next   = 3'd2;
            end else begin
                a_v       = 1'b1;
                a_rep     = ((lead_reg[3:0] == 4'hD) && second_reg[5]) ||
                            ((lead_reg == udec_pkg::LEAD3_FIRST) &&
                             (second_reg[7:5] == 3'b100));
                a_cp      = {lead_reg[3:0], second_reg[5:0], data_byte[5:0]};
                seen_next = 3'd0;
            end
        end else begin
            a_v       = 1'b1;
            a_rep     = (lead_reg[7:1] == udec_pkg::LEAD2_FIRST[7:1]);
            a_cp      = {5'd0, lead_reg[4:0], data_byte[5:0]};
            seen_next = 3'd0;
        end

        if (seen_next == 3'd0) begin
            lead_next   = 8'd0;
            second_next = 8'd0;
            skip_next   = 3'd0;
        end

        if (do_start) begin
            if (!data_byte[7]) begin
                s_v  = 1'b1;
                s_cp = {8'd0, data_byte};
            end else if (data_byte < udec_pkg::LEAD2_FIRST ||
                         data_byte >= udec_pkg::BAD_FIRST) begin
                s_v   = 1'b1;
                s_rep = 1'b1;
            end else begin
                lead_next   = data_byte;
                second_next = 8'd0;
                seen_next   = 3'd1;
                if (data_byte < udec_pkg::LEAD4_FIRST) begin
                    skip_next = 3'd0;
                end else if (data_byte < udec_pkg::LEAD5_FIRST) begin
                    skip_next = udec_pkg::SKIP_LEAD4;
                end else if (data_byte < udec_pkg::LEAD6_FIRST) begin
                    skip_next = udec_pkg::SKIP_LEAD5;
                end else begin
                    skip_next = udec_pkg::SKIP_LEAD6;
                end
            end
        end

        if (eos && seen_next != 3'd0) begin
            f_v         = 1'b1;
            lead_next   = 8'd0;
            second_next = 8'd0;
            seen_next   = 3'd0;
            skip_next   = 3'd0;
        end

        ca = '{code_point: a_rep ? repl_char : a_cp, is_repl: a_rep,
               str_valid: 1'b0, last: 1'b0};
        cs = '{code_point: s_rep ? repl_char : s_cp, is_repl: s_rep,
               str_valid: 1'b0, last: 1'b0};
        cf = '{code_point: repl_char, is_repl: 1'b1, str_valid: 1'b0, last: 1'b0};

        p.count = {1'b0, a_v} + {1'b0, s_v} + {1'b0, f_v};
        p.slot0 = a_v ? ca : (s_v ? cs : cf);
        p.slot1 = (a_v && s_v) ? cs : cf;
        p.slot0.str_valid = !(err_reg || p.slot0.is_repl);
        p.slot1.str_valid = !(err_reg || p.slot0.is_repl || p.slot1.is_repl);
        p.slot0.last      = eos && (p.count == 2'd1);
        p.slot1.last      = eos && (p.count == 2'd2);

        if (eos) begin
            err_next = 1'b0;
        end else begin
            err_next = err_reg ||
                       ((p.count != 2'd0) && p.slot0.is_repl) ||
                       ((p.count == 2'd2) && p.slot1.is_repl);
        end
        push = p;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_reg   <= 8'd0;
            second_reg <= 8'd0;
            seen_reg   <= 3'd0;
            skip_reg   <= 3'd0;
            err_reg    <= 1'b0;
        end else if (go) begin
            lead_reg   <= lead_next;
            second_reg <= second_next;
            seen_reg   <= seen_next;
            skip_reg   <= skip_next;
            err_reg    <= err_next;
        end
    end

endmodule

FILE: hdl/udec_queue.sv
// ----------------------------------------------------------------------------
// udec_queue
// Result queue: takes up to two results per cycle, delivers one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module udec_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push_en,
    input  udec_pkg::udec_push_t    push,
    output logic                    room,
    output logic                    out_valid,
    input  logic                    out_ready,
    output udec_pkg::udec_result_t  out_data
);

    localparam int PW = $clog2(udec_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(udec_pkg::QUEUE_DEPTH + 1);

    udec_pkg::udec_result_t entry_reg [udec_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;
    logic [1:0]    push_cnt;
    logic          pop;

    assign push_cnt  = push_en ? push.count : 2'd0;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_data  = entry_reg[rd_ptr_reg];
    assign room      = (count_reg <= CW'(udec_pkg::QUEUE_DEPTH - 2));

    assign wr_ptr_next = wr_ptr_reg + PW'(push_cnt);
    assign rd_ptr_next = rd_ptr_reg + PW'(pop);
    assign count_next  = count_reg + CW'(push_cnt) - CW'(pop);

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push.slot0;
        end
        if (push_cnt == 2'd2) begin
            entry_reg[wr_ptr_reg + PW'(1)] <= push.slot1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hdl/utf8_stream_decoder.sv
// Path: input register, then combinational decode into the result queue,
// which drives m_axis. Throughput: one byte per cycle while the queue has
// room; the output side moves one result per cycle while m_axis_tready is
// high, so two results from one byte are absorbed by the four-entry queue.
// Reset: aresetn synchronous, active low; clears the pending sequence, the
// sticky error flag and the queue, and sets the replacement character to '_'.
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Streaming UTF-8 to 16-bit code point decoder with replacement on errors.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_string
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] code_point
    output logic [1:0]  m_axis_tuser,   // [0] is_replacement, [1] string_valid
    output logic        m_axis_tlast,   // last
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    logic [15:0]            repl_reg;
    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_eos_reg;
    logic                   go;
    logic                   room;
    udec_pkg::udec_push_t   push;
    udec_pkg::udec_result_t out_data;

    assign go            = in_valid_reg && room;
    assign s_axis_tready = !in_valid_reg || go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            repl_reg <= udec_pkg::REPL_RESET;
        end else if (cfg_we) begin
            repl_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg <= s_axis_tdata;
            in_eos_reg  <= s_axis_tlast;
        end
    end

    udec_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .go        (go),
        .data_byte (in_byte_reg),
        .eos       (in_eos_reg),
        .repl_char (repl_reg),
        .push      (push)
    );

    udec_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_en   (go),
        .push      (push),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data)
    );

    assign m_axis_tdata = out_data.code_point;
    assign m_axis_tuser = {out_data.str_valid, out_data.is_repl};
    assign m_axis_tlast = out_data.last;

endmodule

FILE: hdl/udec_checker.sv
// ----------------------------------------------------------------------------
// udec_checker
// Port-level assertions for the UTF-8 stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
module udec_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
            $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result present right after reset");

    a_repl_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1])
        else $error("replacement with string still marked valid");

    a_no_surrogate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[15:11] != 5'b11011)
        else $error("surrogate decoded as a valid code point");

endmodule

bind utf8_stream_decoder udec_checker u_checker (.*);
